@@ design/cbse_pkg.sv @@
// Shared types, widths, tables and codes for the cubic B-spline evaluator.
`timescale 1ns / 1ps
`default_nettype none

package cbse_pkg;

  localparam int COORD_W = 24;           // signed Q12.12 coordinate
  localparam int LOD_W   = 6;            // level of detail register
  localparam int SQ_W    = 2 * LOD_W;    // k^2, L^2
  localparam int CUBE_W  = 3 * LOD_W;    // k^3, L^3, k^2*L, k*L^2
  localparam int BASIS_W = CUBE_W + 2;   // basis weight, at most 4*L^3
  localparam int BS_W    = BASIS_W + 3;  // signed scratch width for the weights
  localparam int DEN_W   = CUBE_W + 3;   // 6*L^3
  localparam int DIV_W   = DEN_W + 1;    // divisor 2*den
  localparam int QUO_W   = COORD_W + 1;  // offset quotient
  localparam int NUM_W   = QUO_W + DIV_W;
  localparam int REM_W   = DIV_W + 1;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int MUL_A_W = COORD_W + 1;
  localparam int MUL_B_W = BASIS_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = NUM_W + 1;

  localparam logic [LOD_W-1:0] LOD_RESET = LOD_W'(8);

  // coordinate select codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // term index that follows the last product of a dot product
  localparam logic [2:0] TERM_LAST = 3'd4;
  localparam logic [2:0] TERM_P3   = 3'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LOD_W-1:0]          lod_t;
  typedef logic [BASIS_W-1:0]        basis_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] dvsr;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_K2L,
    ST_KL2,
    ST_BASIS,
    ST_MAC,
    ST_DIV,
    ST_EMIT
  } state_t;

  // small constant tables over a 6-bit index
  function automatic logic [SQ_W-1:0] sq_tab(input lod_t v);
    return SQ_W'(v) * SQ_W'(v);
  endfunction

  function automatic logic [CUBE_W-1:0] cube_tab(input lod_t v);
    return CUBE_W'(v) * CUBE_W'(v) * CUBE_W'(v);
  endfunction

  // quotient carries an offset of 2^COORD_W; clamp into the coordinate range
  function automatic coord_t sat_quo(input logic [QUO_W-1:0] q);
    coord_t r;
    if (q[QUO_W-1] && q[QUO_W-2]) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (!q[QUO_W-1] && !q[QUO_W-2]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = q[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/cbse_ifs.sv @@
// Channel interfaces: control points in, samples out, level-of-detail writes.
`timescale 1ns / 1ps
`default_nettype none

interface cbse_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbse_pkg::COORD_W-1:0] ctrl_x;
  logic signed [cbse_pkg::COORD_W-1:0] ctrl_y;
  logic signed [cbse_pkg::COORD_W-1:0] ctrl_z;
  logic                                start_curve;
  modport source (output valid, ctrl_x, ctrl_y, ctrl_z, start_curve, input ready);
  modport sink   (input valid, ctrl_x, ctrl_y, ctrl_z, start_curve, output ready);
endinterface

interface cbse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbse_pkg::COORD_W-1:0] out_x;
  logic signed [cbse_pkg::COORD_W-1:0] out_y;
  logic signed [cbse_pkg::COORD_W-1:0] out_z;
  logic                                last_sample;
  modport source (output valid, out_x, out_y, out_z, last_sample, input ready);
  modport sink   (input valid, out_x, out_y, out_z, last_sample, output ready);
endinterface

interface cbse_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cbse_pkg::LOD_W-1:0]        level_of_detail;
  modport source (output valid, level_of_detail, input ready);
  modport sink   (input valid, level_of_detail, output ready);
endinterface

`default_nettype wire

@@ design/cbse_mul.sv @@
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module cbse_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [cbse_pkg::MUL_A_W-1:0] a,
  input  logic signed [cbse_pkg::MUL_B_W-1:0] b,
  output logic signed [cbse_pkg::PROD_W-1:0]  prod
);
  import cbse_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

@@ design/cbse_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cbse_div (
  input  logic                clk,
  input  logic                rst_n,
  input  cbse_pkg::div_req_t  req,
  output cbse_pkg::div_rsp_t  rsp
);
  import cbse_pkg::*;

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [REM_W-1:0] trial;

  // quotient is known to fit QUO_W bits, so the upper dividend bits start as remainder
  always_comb begin
    trial = {rem_r[REM_W-2:0], quo_r[QUO_W-1]};
    if (trial >= {1'b0, dvsr_r}) begin
      rem_nxt = trial - {1'b0, dvsr_r};
      quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (req.start) begin
        cnt_r <= CNT_W'(QUO_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= {1'b0, req.num[NUM_W-1:QUO_W]};
      quo_r  <= req.num[QUO_W-1:0];
      dvsr_r <= req.dvsr;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

@@ design/cubic_bspline_evaluator_top.sv @@
// Top level of the uniform cubic B-spline evaluator: sequencer, window and output register.
`timescale 1ns / 1ps
`default_nettype none

// Uniform cubic B-spline evaluator.
// in_ch  : one control point per beat (x, y, z in signed Q12.12, start_curve).
//          start_curve empties the window so the point opens a new curve.
//          The first three points of a curve only fill the window and give
//          no samples. Every later point evaluates the segment over the
//          last four points and gives level_of_detail+1 samples at u = k/L.
// out_ch : one sample per beat; last_sample marks k = L. Samples are rounded
//          to nearest (ties up) and clamped to the coordinate range.
// cfg_ch : writes level_of_detail (reset 8); always ready, write it only while
//          no point is in flight. Zero gives a single sample at u = 0.
// Compute : per sample, 2 basis products and, per axis, 4 products on the
//          one shared multiplier plus the bit-serial divider (one quotient
//          bit per cycle, 25 bits). in_ch is ready only when the sequencer
//          is idle.
// Stall  : a finished sample waits in the output register; the next sample is
//          computed meanwhile and held until the register frees up. The next
//          point can be taken while the last sample still waits.
// Reset  : rst_n, synchronous. Clears the window count, the sequencer and the
//          output valid, and sets level_of_detail back to 8.

module cubic_bspline_evaluator_top (
  input  logic          clk,
  input  logic          rst_n,
  cbse_in_if.sink       in_ch,
  cbse_out_if.source    out_ch,
  cbse_cfg_if.sink      cfg_ch
);
  import cbse_pkg::*;

  localparam logic [QUO_W-1:0] QUO_LO = QUO_W'(1) << (COORD_W - 1);
  localparam logic [QUO_W-1:0] QUO_HI = QUO_W'(3) << (COORD_W - 1);

  state_t state_r, state_nxt;

  lod_t   lod_r;
  coord_t win_x_r [3];
  coord_t win_y_r [3];
  coord_t win_z_r [3];
  coord_t px_r, py_r, pz_r;
  logic [1:0] held_r;

  lod_t              k_r;
  logic [SQ_W-1:0]   l2_r;
  logic [CUBE_W-1:0] l3_r;
  logic [DEN_W-1:0]  den_r;
  logic [CUBE_W-1:0] k2l_r;
  basis_t            b_r [4];
  logic [1:0]        coord_r;
  logic [2:0]        j_r;
  logic [ACC_W-1:0]  acc_r;
  coord_t            res_x_r, res_y_r, res_z_r;

  logic   out_valid_r;
  coord_t out_x_r, out_y_r, out_z_r;
  logic   out_last_r;

  // control decode
  logic       in_acc, fill, emit_load, last_k;
  logic [1:0] fill_idx;
  lod_t       lod_eff;

  // shared multiplier
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  // operand pick and accumulate
  coord_t           wx, wy, wz, w_sel;
  basis_t           b_sel;
  logic [DIV_W-1:0] dvsr;
  logic [ACC_W-1:0] acc_init, acc_add;

  // basis weights
  logic [CUBE_W-1:0]     k3, m3, kl2;
  lod_t                  m;
  logic signed [BS_W-1:0] k3s, k2ls, kl2s, l3s, b1s, b2s;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // ---------------------------------------------------------------- control
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign fill         = in_ch.start_curve || (held_r != 2'd3);
  assign fill_idx     = in_ch.start_curve ? 2'd0 : held_r;
  assign emit_load    = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign last_k       = (k_r == lod_r);
  // level zero evaluates the k = 0 sample of level one: weights 1,4,1,0 over 6
  assign lod_eff      = (lod_r == '0) ? LOD_W'(1) : lod_r;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !fill) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: state_nxt = ST_K2L;
      ST_K2L:   state_nxt = ST_KL2;
      ST_KL2:   state_nxt = ST_BASIS;
      ST_BASIS: state_nxt = ST_MAC;
      ST_MAC: begin
        if (j_r == TERM_LAST) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (coord_r == AX_Z) ? ST_EMIT : ST_MAC;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_nxt = last_k ? ST_IDLE : ST_K2L;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------- operand select
  always_comb begin
    wx = px_r;
    wy = py_r;
    wz = pz_r;
    if (j_r < TERM_P3) begin
      wx = win_x_r[j_r[1:0]];
      wy = win_y_r[j_r[1:0]];
      wz = win_z_r[j_r[1:0]];
    end
    case (coord_r)
      AX_X:    w_sel = wx;
      AX_Y:    w_sel = wy;
      default: w_sel = wz;
    endcase
    b_sel = b_r[j_r[1:0]];
  end

  always_comb begin
    mul_en = 1'b0;
    case (state_r)
      ST_K2L: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(sq_tab(k_r)));
        mul_b  = $signed(MUL_B_W'(lod_eff));
      end
      ST_KL2: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(k_r));
        mul_b  = $signed(MUL_B_W'(l2_r));
      end
      default: begin
        mul_en = (state_r == ST_MAC) && (j_r != TERM_LAST);
        mul_a  = MUL_A_W'(w_sel);
        mul_b  = $signed({1'b0, b_sel});
      end
    endcase
  end

  cbse_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Numerator 2*num + den, offset by 2^COORD_W divisors so it stays positive.
  assign dvsr     = {den_r, 1'b0};
  assign acc_init = ACC_W'(den_r) + (ACC_W'(dvsr) << COORD_W);
  assign acc_add  = acc_r + {{(ACC_W-PROD_W-1){prod[PROD_W-1]}}, prod, 1'b0};

  assign div_req.start = (state_r == ST_MAC) && (j_r == TERM_LAST);
  assign div_req.num   = acc_add[NUM_W-1:0];
  assign div_req.dvsr  = dvsr;

  cbse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------- basis weights
  always_comb begin
    m    = lod_eff - k_r;
    m3   = cube_tab(m);
    k3   = cube_tab(k_r);
    kl2  = prod[CUBE_W-1:0];
    k3s  = BS_W'(k3);
    k2ls = BS_W'(k2l_r);
    kl2s = BS_W'(kl2);
    l3s  = BS_W'(l3_r);
    // 3k^3 - 6k^2 L + 4L^3
    b1s  = (k3s <<< 1) + k3s - (k2ls <<< 2) - (k2ls <<< 1) + (l3s <<< 2);
    // -3k^3 + 3k^2 L + 3k L^2 + L^3
    b2s  = l3s - (k3s <<< 1) - k3s + (k2ls <<< 1) + k2ls + (kl2s <<< 1) + kl2s;
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (fill) begin
        win_x_r[fill_idx] <= in_ch.ctrl_x;
        win_y_r[fill_idx] <= in_ch.ctrl_y;
        win_z_r[fill_idx] <= in_ch.ctrl_z;
      end else begin
        px_r <= in_ch.ctrl_x;
        py_r <= in_ch.ctrl_y;
        pz_r <= in_ch.ctrl_z;
      end
    end
    case (state_r)
      ST_SETUP: begin
        l2_r  <= sq_tab(lod_eff);
        l3_r  <= cube_tab(lod_eff);
        den_r <= (DEN_W'(cube_tab(lod_eff)) << 2) + (DEN_W'(cube_tab(lod_eff)) << 1);
        k_r   <= '0;
      end
      ST_KL2: begin
        k2l_r <= prod[CUBE_W-1:0];
      end
      ST_BASIS: begin
        b_r[0]  <= BASIS_W'(m3);
        b_r[1]  <= b1s[BASIS_W-1:0];
        b_r[2]  <= b2s[BASIS_W-1:0];
        b_r[3]  <= BASIS_W'(k3);
        coord_r <= AX_X;
        j_r     <= '0;
      end
      ST_MAC: begin
        acc_r <= (j_r == '0) ? acc_init : acc_add;
        j_r   <= j_r + 3'd1;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          case (coord_r)
            AX_X:    res_x_r <= sat_quo(div_rsp.quo);
            AX_Y:    res_y_r <= sat_quo(div_rsp.quo);
            default: res_z_r <= sat_quo(div_rsp.quo);
          endcase
          coord_r <= coord_r + 2'd1;
          j_r     <= '0;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          if (last_k) begin
            // slide the window: oldest out, new point in
            win_x_r[0] <= win_x_r[1];
            win_x_r[1] <= win_x_r[2];
            win_x_r[2] <= px_r;
            win_y_r[0] <= win_y_r[1];
            win_y_r[1] <= win_y_r[2];
            win_y_r[2] <= py_r;
            win_z_r[0] <= win_z_r[1];
            win_z_r[1] <= win_z_r[2];
            win_z_r[2] <= pz_r;
          end else begin
            k_r <= k_r + LOD_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lod_r       <= LOD_RESET;
      held_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        lod_r <= cfg_ch.level_of_detail;
      end
      if (in_acc && fill) begin
        held_r <= fill_idx + 2'd1;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_x_r    <= res_x_r;
      out_y_r    <= res_y_r;
      out_z_r    <= res_z_r;
      out_last_r <= last_k;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_x       = out_x_r;
  assign out_ch.out_y       = out_y_r;
  assign out_ch.out_z       = out_z_r;
  assign out_ch.last_sample = out_last_r;

  // ------------------------------------------------------------- assertions
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide step");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_SETUP) |-> (k_r <= lod_r))
    else $error("sample index ran past level of detail");

  // convex weights keep every sample within the hull of the control points
  a_quo_band: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (div_rsp.quo >= QUO_LO && div_rsp.quo <= QUO_HI))
    else $error("quotient outside the coordinate band");

endmodule

`default_nettype wire
